// File: sv/cmac_pkg.sv
// Shared types and operation codes for the complex multiply-accumulate pipeline.
`timescale 1ns / 1ps
package cmac_pkg;

  typedef enum logic [1:0] {
    OP_WIDE  = 2'd0,
    OP_Q15   = 2'd1,
    OP_ROUND = 2'd2
  } cmac_op_e;

  localparam int unsigned HalfW   = 16;
  localparam int unsigned WordW   = 32;
  localparam int unsigned AccW    = 64;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned Q15Shift = 15;

  typedef struct packed {
    logic [1:0]        op;
    logic [AccW-1:0]   d;
    logic [ShiftW-1:0] sh;
    logic [HalfW-1:0]  rnd;
  } cmac_ctl_t;

  typedef struct packed {
    logic [WordW-1:0] rr;
    logic [WordW-1:0] ii;
    logic [WordW-1:0] ri;
    logic [WordW-1:0] ir;
  } cmac_prod_t;

  typedef struct packed {
    logic [WordW-1:0] re;
    logic [WordW-1:0] im;
  } cmac_cplx_t;

endpackage

// File: sv/cmac_mul.sv
// First pipeline stage: the four signed 16x16 partial products.
`timescale 1ns / 1ps
module cmac_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        src_a_i,
  input  logic [31:0]        src_b_i,
  input  cmac_pkg::cmac_ctl_t ctl_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cmac_pkg::cmac_prod_t prod_o,
  output cmac_pkg::cmac_ctl_t  ctl_o
);
  import cmac_pkg::*;

  logic       valid_q;
  cmac_prod_t prod_d, prod_q;
  cmac_ctl_t  ctl_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    prod_d.rr = WordW'($signed(src_a_i[15:0]) * $signed(src_b_i[15:0]));
    prod_d.ii = WordW'($signed(src_a_i[31:16]) * $signed(src_b_i[31:16]));
    prod_d.ri = WordW'($signed(src_a_i[15:0]) * $signed(src_b_i[31:16]));
    prod_d.ir = WordW'($signed(src_a_i[31:16]) * $signed(src_b_i[15:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      prod_q <= prod_d;
      ctl_q  <= ctl_i;
    end
  end

  assign out_valid_o = valid_q;
  assign prod_o      = prod_q;
  assign ctl_o       = ctl_q;

  a_stall_keeps_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q)
    else $error("stage one dropped a stalled item");

  a_stall_keeps_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> $stable(prod_q) && $stable(ctl_q))
    else $error("stage one changed a stalled item");

  a_empty_is_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |-> in_ready_o)
    else $error("empty stage one refused a transfer");

endmodule

// File: sv/cmac_sum.sv
// Second pipeline stage: real and imaginary sums of the partial products.
`timescale 1ns / 1ps
module cmac_sum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cmac_pkg::cmac_prod_t prod_i,
  input  cmac_pkg::cmac_ctl_t  ctl_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cmac_pkg::cmac_cplx_t cplx_o,
  output cmac_pkg::cmac_ctl_t  ctl_o
);
  import cmac_pkg::*;

  logic       valid_q;
  cmac_cplx_t cplx_d, cplx_q;
  cmac_ctl_t  ctl_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    cplx_d.re = prod_i.rr - prod_i.ii;
    cplx_d.im = prod_i.ri + prod_i.ir;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cplx_q <= cplx_d;
      ctl_q  <= ctl_i;
    end
  end

  assign out_valid_o = valid_q;
  assign cplx_o      = cplx_q;
  assign ctl_o       = ctl_q;

endmodule

// File: sv/cmac_fin.sv
// Third pipeline stage: accumulate, scale or round, and the output register.
`timescale 1ns / 1ps
module cmac_fin (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cmac_pkg::cmac_cplx_t cplx_i,
  input  cmac_pkg::cmac_ctl_t  ctl_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          result_o
);
  import cmac_pkg::*;

  logic              valid_q;
  logic [AccW-1:0]   result_d, result_q;
  logic [WordW-1:0]  re_rnd, im_rnd;
  logic [WordW-1:0]  re_asr, im_asr;
  logic [WordW-1:0]  re_q15, im_q15;
  logic [HalfW-1:0]  re_h, im_h;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    re_rnd = cplx_i.re + {{(WordW-HalfW){1'b0}}, ctl_i.rnd};
    im_rnd = cplx_i.im + {{(WordW-HalfW){1'b0}}, ctl_i.rnd};
    re_asr = WordW'($signed(re_rnd) >>> ctl_i.sh);
    im_asr = WordW'($signed(im_rnd) >>> ctl_i.sh);
    re_q15 = WordW'($signed(cplx_i.re) >>> Q15Shift);
    im_q15 = WordW'($signed(cplx_i.im) >>> Q15Shift);
    re_h   = '0;
    im_h   = '0;
    result_d = '0;
    unique case (ctl_i.op)
      OP_WIDE: begin
        result_d = {cplx_i.im + ctl_i.d[63:32], cplx_i.re + ctl_i.d[31:0]};
      end
      OP_Q15: begin
        re_h = re_q15[HalfW-1:0] + ctl_i.d[15:0];
        im_h = im_q15[HalfW-1:0] + ctl_i.d[31:16];
        result_d = {{(AccW-2*HalfW){1'b0}}, im_h, re_h};
      end
      OP_ROUND: begin
        re_h = re_asr[HalfW-1:0];
        im_h = im_asr[HalfW-1:0];
        result_d = {{(AccW-2*HalfW){1'b0}}, im_h, re_h};
      end
      default: begin
        result_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// File: sv/complex_multiply_accumulate_alu.sv
// Top level of the pipelined complex multiply-accumulate unit.
//
// Input channel: in_valid_i / in_ready_o carry operation_i, src_a_i, src_b_i,
// src_d_i, shift_amount_i and round_value_i; a transfer happens at a rising
// edge where both are high. Output channel: out_valid_o / out_ready_i carry
// result_o in the same way.
// The unit is a three-stage pipeline: partial products, complex sums, then
// accumulate, scale or round into the output register. An item accepted into
// the first stage moves through the sum register into the output register, where
// it is shown on result_o until it leaves in an output transfer.
// Throughput is one item per cycle while out_ready_i stays high; each stage holds
// one item and its own valid bit, so the pipeline holds up to three items in flight.
// When out_ready_i is low the stages fill up behind the output register and
// in_ready_o falls only once every stage holds an item; nothing is lost or
// repeated. Reset clears all valid bits, so the pipeline starts empty and
// in_ready_o is high right after reset.
`timescale 1ns / 1ps
module complex_multiply_accumulate_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] src_a_i,
  input  logic [31:0] src_b_i,
  input  logic [63:0] src_d_i,
  input  logic [4:0]  shift_amount_i,
  input  logic [15:0] round_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_o
);
  import cmac_pkg::*;

  cmac_ctl_t  ctl_in, ctl_s1, ctl_s2;
  cmac_prod_t prod_s1;
  cmac_cplx_t cplx_s2;
  logic       valid_s1, ready_s1, valid_s2, ready_s2;

  always_comb begin
    ctl_in.op  = operation_i;
    ctl_in.d   = src_d_i;
    ctl_in.sh  = shift_amount_i;
    ctl_in.rnd = round_value_i;
  end

  cmac_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .src_a_i     (src_a_i),
    .src_b_i     (src_b_i),
    .ctl_i       (ctl_in),
    .out_valid_o (valid_s1),
    .out_ready_i (ready_s1),
    .prod_o      (prod_s1),
    .ctl_o       (ctl_s1)
  );

  cmac_sum u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_s1),
    .in_ready_o  (ready_s1),
    .prod_i      (prod_s1),
    .ctl_i       (ctl_s1),
    .out_valid_o (valid_s2),
    .out_ready_i (ready_s2),
    .cplx_o      (cplx_s2),
    .ctl_o       (ctl_s2)
  );

  cmac_fin u_fin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_s2),
    .in_ready_o  (ready_s2),
    .cplx_i      (cplx_s2),
    .ctl_i       (ctl_s2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_o)
  );

endmodule

// File: bench/tb.sv
// Self-checking bench for the complex multiply-accumulate unit: directed table, then random traffic.
`timescale 1ns / 1ps
module tb;
  import cmac_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int NumDirected = 19;
  localparam int NumRandom = 1230;
  localparam int NoIdleItems = 150;
  localparam int PauseAt = 700;
  localparam int HoldAt = 400;
  localparam int LongHold = 80;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    logic [63:0] d;
    logic [4:0]  sh;
    logic [15:0] rnd;
    logic        fixed;
    logic [63:0] res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic [31:0] src_a_i;
  logic [31:0] src_b_i;
  logic [63:0] src_d_i;
  logic [4:0]  shift_amount_i;
  logic [15:0] round_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] result_o;

  logic        drv_fixed;
  logic [63:0] drv_res;

  logic [63:0] result_q[$];
  int          n_accepted;
  int          err_count;
  bit          long_hold_done;

  stim_row_t dir_rows [NumDirected] = '{
    '{OP_WIDE, 32'h0000_0000, 32'h0000_0000, 64'h0, 5'd0, 16'h0000,
      1'b1, 64'h0},
    '{OP_WIDE, 32'h0000_0000, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 16'h0000,
      1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{OP_WIDE, 32'h8000_8000, 32'h8000_8000, 64'h0, 5'd0, 16'h0000,
      1'b1, 64'h8000_0000_0000_0000},
    '{OP_WIDE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 5'd0, 16'h0000,
      1'b1, 64'h0000_0002_0000_0000},
    '{OP_WIDE, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 64'h1234_5678_9ABC_DEF0, 5'd0, 16'h0000,
      1'b0, 64'h0},
    '{OP_WIDE, 32'h0000_7FFF, 32'h8000_0000, 64'h0, 5'd0, 16'h0000,
      1'b0, 64'h0},
    '{OP_WIDE, 32'h8000_8000, 32'h7FFF_7FFF, 64'h8000_0000_8000_0000, 5'd31, 16'hFFFF,
      1'b0, 64'h0},
    '{OP_Q15, 32'h0000_0000, 32'h0000_0000, 64'h0000_0000_7FFF_8000, 5'd0, 16'h0000,
      1'b1, 64'h0000_0000_7FFF_8000},
    '{OP_Q15, 32'h0000_0000, 32'h0000_0000, 64'hFFFF_FFFF_7FFF_8000, 5'd31, 16'hFFFF,
      1'b1, 64'h0000_0000_7FFF_8000},
    '{OP_Q15, 32'h8000_8000, 32'h8000_8000, 64'h0, 5'd0, 16'h0000,
      1'b0, 64'h0},
    '{OP_Q15, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 16'h0000,
      1'b0, 64'h0},
    '{OP_Q15, 32'h8000_8000, 32'h8000_8000, 64'hFFFF_FFFF_8000_7FFF, 5'd7, 16'h1234,
      1'b0, 64'h0},
    '{OP_ROUND, 32'h0000_0000, 32'h0000_0000, 64'h0, 5'd0, 16'hFFFF,
      1'b1, 64'h0000_0000_FFFF_FFFF},
    '{OP_ROUND, 32'h0000_0000, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 16'hFFFF,
      1'b1, 64'h0},
    '{OP_ROUND, 32'h8000_8000, 32'h8000_8000, 64'h0, 5'd31, 16'h0000,
      1'b0, 64'h0},
    '{OP_ROUND, 32'h8000_8000, 32'h8000_8000, 64'h0, 5'd16, 16'h8000,
      1'b0, 64'h0},
    '{OP_ROUND, 32'h7FFF_8000, 32'h8000_7FFF, 64'h0, 5'd15, 16'h4000,
      1'b0, 64'h0},
    '{OpUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 16'hFFFF,
      1'b1, 64'h0},
    '{OpUnused, 32'h0000_0000, 32'h0000_0000, 64'h0, 5'd0, 16'h0000,
      1'b1, 64'h0}
  };

  complex_multiply_accumulate_alu dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .src_a_i       (src_a_i),
    .src_b_i       (src_b_i),
    .src_d_i       (src_d_i),
    .shift_amount_i(shift_amount_i),
    .round_value_i (round_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_o      (result_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [63:0] cmac_predict(logic [1:0] op, logic [31:0] a, logic [31:0] b,
                                               logic [63:0] d, logic [4:0] sh,
                                               logic [15:0] rnd);
    logic signed [31:0] ar, ai, br, bi;
    logic signed [31:0] re, im;
    logic signed [31:0] re_t, im_t;
    logic [31:0]        r, i;
    ar = {{16{a[15]}}, a[15:0]};
    ai = {{16{a[31]}}, a[31:16]};
    br = {{16{b[15]}}, b[15:0]};
    bi = {{16{b[31]}}, b[31:16]};
    re = ar * br - ai * bi;
    im = ar * bi + ai * br;
    case (op)
      OP_WIDE: begin
        r = re + d[31:0];
        i = im + d[63:32];
        return {i, r};
      end
      OP_Q15: begin
        re_t = re >>> Q15Shift;
        im_t = im >>> Q15Shift;
        r = re_t + {{16{d[15]}}, d[15:0]};
        i = im_t + {{16{d[31]}}, d[31:16]};
        return {32'h0, i[15:0], r[15:0]};
      end
      OP_ROUND: begin
        re_t = re + {16'h0, rnd};
        im_t = im + {16'h0, rnd};
        r = re_t >>> sh;
        i = im_t >>> sh;
        return {32'h0, i[15:0], r[15:0]};
      end
      default: return 64'h0;
    endcase
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // Transfers and results are both observed at the rising edge.
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("unexpected result transfer: result %h", result_o);
          err_count++;
        end else begin
          want = result_q.pop_front();
          if (result_o !== want) begin
            $error("result mismatch: expected %h, actual %h", want, result_o);
            err_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (drv_fixed)
          result_q.push_back(drv_res);
        else
          result_q.push_back(cmac_predict(operation_i, src_a_i, src_b_i, src_d_i,
                                          shift_amount_i, round_value_i));
        n_accepted++;
      end
    end
  end

  task automatic send_item(stim_row_t row, bit no_idle);
    int gap;
    in_valid_i     <= 1'b1;
    operation_i    <= row.op;
    src_a_i        <= row.a;
    src_b_i        <= row.b;
    src_d_i        <= row.d;
    shift_amount_i <= row.sh;
    round_value_i  <= row.rnd;
    drv_fixed      <= row.fixed;
    drv_res        <= row.res;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  initial begin
    stim_row_t row;
    int        r;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = '0;
    src_a_i        = '0;
    src_b_i        = '0;
    src_d_i        = '0;
    shift_amount_i = '0;
    round_value_i  = '0;
    drv_fixed      = 1'b0;
    drv_res        = '0;
    n_accepted     = 0;
    err_count      = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[k]) send_item(dir_rows[k], 1'b1);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == PauseAt) begin
        in_valid_i <= 1'b0;
        wait (result_q.size() == 0);
        @(negedge clk_i);
      end
      r = $urandom_range(0, 31);
      row.op    = (r == 0) ? OpUnused : 2'(r % 3);
      row.a     = ($urandom_range(0, 1) == 1) ? $urandom : {pick_half(), pick_half()};
      row.b     = ($urandom_range(0, 1) == 1) ? $urandom : {pick_half(), pick_half()};
      row.d     = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom}
                                              : {pick_half(), pick_half(), pick_half(),
                                                 pick_half()};
      row.sh    = 5'($urandom_range(0, 31));
      row.rnd   = pick_half();
      row.fixed = 1'b0;
      row.res   = '0;
      send_item(row, n < NoIdleItems);
    end
    in_valid_i <= 1'b0;

    wait (result_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && result_q.size() == 0) begin
      $display("[complex_multiply_accumulate_alu] OK");
    end else begin
      $display("[complex_multiply_accumulate_alu] ERROR");
    end
    $finish;
  end

  // The output side stalls in runs of random length, with one long hold-off.
  initial begin
    int stretch;
    int gap;
    out_ready_i    = 1'b0;
    long_hold_done = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    out_ready_i <= 1'b1;
    repeat (200) @(negedge clk_i);
    forever begin
      if (!long_hold_done && n_accepted >= HoldAt) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        long_hold_done = 1'b1;
      end else begin
        stretch = $urandom_range(1, 40);
        out_ready_i <= 1'b1;
        repeat (stretch) @(negedge clk_i);
        gap = idle_len();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[complex_multiply_accumulate_alu] ERROR");
    $finish;
  end

endmodule
